### rtl/point_cloud_bin_parser_assert.svh
// Assertion macros shared by the front and queue modules of the parser.
`ifndef POINT_CLOUD_BIN_PARSER_ASSERT_SVH
`define POINT_CLOUD_BIN_PARSER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define PCBP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pcbp assertion failed");

// A consequence that holds in the same cycle as its antecedent.
`define PCBP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcbp assertion failed");

// A consequence that holds in the cycle after its antecedent.
`define PCBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcbp assertion failed");

`endif

### rtl/pcbp_pkg.sv
package pcbp_pkg;

  localparam int CNT_W  = 32;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_POINT    = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_FMT_ERR  = 2'd2,
    KIND_READ_ERR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_VER,
    PH_NGROUPS,
    PH_GROUPLEN,
    PH_PAIRS,
    PH_NPOINTS,
    PH_RECORD,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] x_bits;
    logic [31:0] y_bits;
    logic [31:0] z_bits;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        all_done;
  } out_item_t;

  // Parsed result waiting between the parser and the output stage.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] x_bits;
    logic [31:0] y_bits;
    logic [31:0] z_bits;
    logic [15:0] color565;
    logic        all_done;
  } evt_t;

endpackage

### rtl/pcbp_front.sv
`include "point_cloud_bin_parser_assert.svh"

module pcbp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  pcbp_pkg::in_item_t in_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               q_full,
  output logic               ev_push,
  output pcbp_pkg::evt_t     ev_data
);
  import pcbp_pkg::*;

  localparam logic [3:0] REC_COLOR_HI = 4'd12;
  localparam logic [3:0] REC_COLOR_LO = 4'd13;

  phase_t             phase_r, phase_nxt;
  logic [3:0]         rbi_r, rbi_nxt;
  logic [CNT_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   groups_r, groups_nxt;
  logic [CNT_W-1:0]   pw_r, pw_nxt;
  logic [CNT_W-1:0]   points_r, points_nxt;
  logic [31:0]        crd_r [3];
  logic [31:0]        crd_nxt [3];
  logic [7:0]         colh_r, colh_nxt;
  logic [15:0]        ver_r, ver_nxt;
  logic [15:0]        files_r, files_nxt;
  logic               sticky_r, sticky_nxt;
  logic [15:0]        expf_r;

  logic               accept;
  logic               ev_valid;
  evt_t               ev;
  phase_t             ph_e;
  logic [3:0]         rbi_e;
  logic [CNT_W-1:0]   acc_sh;
  logic [CNT_W-1:0]   cnt_pos;
  logic [CNT_W-1:0]   grp_dec;
  logic [CNT_W-1:0]   pw_dec;
  logic [15:0]        files_sat;
  logic               idle;
  logic [7:0]         b;

  assign accept  = in_push && !q_full;
  assign ev_push = accept && ev_valid;
  assign ev_data = ev;

  always_comb begin
    b         = in_data.data_byte;
    ph_e      = in_data.first_byte ? PH_VER : phase_r;
    rbi_e     = in_data.first_byte ? 4'd0 : rbi_r;
    acc_sh    = {acc_r[CNT_W-8:0], b[6:0]};
    cnt_pos   = (acc_sh != '0 && !acc_sh[CNT_W-1]) ? acc_sh : '0;
    grp_dec   = groups_r - CNT_W'(1);
    pw_dec    = pw_r - CNT_W'(1);
    files_sat = (files_r != 16'hFFFF) ? files_r + 16'd1 : files_r;
    idle      = (phase_r == PH_VER) && (rbi_r == 4'd0);

    phase_nxt  = phase_r;
    rbi_nxt    = rbi_r;
    acc_nxt    = acc_r;
    groups_nxt = groups_r;
    pw_nxt     = pw_r;
    points_nxt = points_r;
    crd_nxt    = crd_r;
    colh_nxt   = colh_r;
    ver_nxt    = ver_r;
    files_nxt  = files_r;
    sticky_nxt = sticky_r;
    ev_valid   = 1'b0;
    ev         = '0;

    if (accept && !sticky_r) begin
      if (in_data.stream_end) begin
        if (in_data.first_byte || (!idle && phase_r != PH_DONE)) begin
          sticky_nxt = 1'b1;
          ev_valid   = 1'b1;
          ev.kind    = KIND_READ_ERR;
        end else if (phase_r == PH_DONE) begin
          files_nxt   = files_sat;
          phase_nxt   = PH_VER;
          rbi_nxt     = 4'd0;
          acc_nxt     = '0;
          ev_valid    = 1'b1;
          ev.kind     = KIND_DONE;
          ev.all_done = (files_sat == expf_r);
        end
      end else begin
        phase_nxt = ph_e;
        rbi_nxt   = rbi_e;
        case (ph_e)
          PH_VER: begin
            case (rbi_e[1:0])
              2'd0: begin
                ver_nxt = {b, 8'h00};
                rbi_nxt = rbi_e + 4'd1;
              end
              2'd1: begin
                ver_nxt = {ver_r[15:8], b};
                rbi_nxt = rbi_e + 4'd1;
              end
              2'd2: begin
                colh_nxt = b;
                rbi_nxt  = rbi_e + 4'd1;
              end
              default: begin
                rbi_nxt = 4'd0;
                if (ver_r != 16'd1 || {colh_r, b} != 16'd0) begin
                  sticky_nxt = 1'b1;
                  ev_valid   = 1'b1;
                  ev.kind    = KIND_FMT_ERR;
                end else begin
                  acc_nxt   = '0;
                  phase_nxt = PH_NGROUPS;
                end
              end
            endcase
          end
          PH_NGROUPS, PH_GROUPLEN, PH_PAIRS, PH_NPOINTS: begin
            if (!b[7]) begin
              acc_nxt = acc_sh;
            end else begin
              acc_nxt = '0;
              case (ph_e)
                PH_NGROUPS: begin
                  groups_nxt = cnt_pos;
                  phase_nxt  = (cnt_pos != '0) ? PH_GROUPLEN : PH_NPOINTS;
                end
                PH_GROUPLEN: begin
                  groups_nxt = grp_dec;
                  pw_nxt     = {cnt_pos[CNT_W-2:0], 1'b0};
                  if (cnt_pos != '0) begin
                    phase_nxt = PH_PAIRS;
                  end else begin
                    phase_nxt = (grp_dec != '0) ? PH_GROUPLEN : PH_NPOINTS;
                  end
                end
                PH_PAIRS: begin
                  pw_nxt = pw_dec;
                  if (pw_dec == '0) begin
                    phase_nxt = (groups_r != '0) ? PH_GROUPLEN : PH_NPOINTS;
                  end
                end
                default: begin
                  points_nxt = cnt_pos;
                  rbi_nxt    = 4'd0;
                  phase_nxt  = (cnt_pos != '0) ? PH_RECORD : PH_DONE;
                end
              endcase
            end
          end
          PH_RECORD: begin
            if (rbi_e < REC_COLOR_HI) begin
              for (int k = 0; k < 3; k++) begin
                if (rbi_e[3:2] == 2'(k)) begin
                  crd_nxt[k] = {crd_r[k][23:0], b};
                end
              end
              rbi_nxt = rbi_e + 4'd1;
            end else if (rbi_e == REC_COLOR_HI) begin
              colh_nxt = b;
              rbi_nxt  = REC_COLOR_LO;
            end else begin
              ev_valid    = 1'b1;
              ev.kind     = KIND_POINT;
              ev.x_bits   = crd_r[0];
              ev.y_bits   = crd_r[1];
              ev.z_bits   = crd_r[2];
              ev.color565 = {colh_r, b};
              rbi_nxt     = 4'd0;
              if (points_r != '0) begin
                points_nxt = points_r - CNT_W'(1);
              end
              if (points_r <= CNT_W'(1)) begin
                phase_nxt = PH_DONE;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_VER;
      rbi_r    <= 4'd0;
      acc_r    <= '0;
      groups_r <= '0;
      pw_r     <= '0;
      points_r <= '0;
      files_r  <= 16'd0;
      sticky_r <= 1'b0;
      expf_r   <= 16'd1;
    end else begin
      phase_r  <= phase_nxt;
      rbi_r    <= rbi_nxt;
      acc_r    <= acc_nxt;
      groups_r <= groups_nxt;
      pw_r     <= pw_nxt;
      points_r <= points_nxt;
      files_r  <= files_nxt;
      sticky_r <= sticky_nxt;
      if (cfg_we) begin
        expf_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    crd_r  <= crd_nxt;
    colh_r <= colh_nxt;
    ver_r  <= ver_nxt;
  end

  `PCBP_ASSERT_IMPLY(a_sticky_silent, sticky_r, !ev_push)
  `PCBP_ASSERT_IMPLY(a_ver_index, phase_r == PH_VER, rbi_r <= 4'd3)
  `PCBP_ASSERT_IMPLY(a_record_has_points, phase_r == PH_RECORD, points_r != '0)
  `PCBP_ASSERT_NEXT(a_error_sticks, ev_push && ev_data.kind == KIND_READ_ERR, sticky_r)

endmodule

### rtl/pcbp_fifo.sv
`include "point_cloud_bin_parser_assert.svh"

module pcbp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  pcbp_pkg::evt_t wdata_i,
  input  logic           pop_i,
  output pcbp_pkg::evt_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);
  import pcbp_pkg::*;

  evt_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_r == '0);
  assign rdata_o = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_i ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

  `PCBP_ASSERT_ALWAYS(a_cnt_range, cnt_r <= QCNT_W'(QDEPTH))
  `PCBP_ASSERT_IMPLY(a_no_overflow, push_i, !full_o)
  `PCBP_ASSERT_IMPLY(a_no_underflow, pop_i, !empty_o)

endmodule

### rtl/pcbp_back.sv
module pcbp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pcbp_pkg::evt_t      q_data,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output pcbp_pkg::out_item_t out_data
);
  import pcbp_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t out_r, out_nxt;

  // Exact floor(v * 255 / 31) as 8v plus floor(7v / 31).
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [7:0] t;
    logic [7:0] s;
    t = {v, 3'b000} - {3'b000, v};
    s = t + {5'b00000, t[7:5]} + 8'd1;
    return {v, 3'b000} + {5'b00000, s[7:5]};
  endfunction

  // Exact floor(v * 255 / 63) as 4v plus floor(v / 21).
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [1:0] q;
    q = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
    return {v, 2'b00} + {6'b000000, q};
  endfunction

  assign q_pop     = !q_empty && (!valid_r || out_pop);
  assign out_empty = !valid_r;
  assign out_data  = out_r;

  always_comb begin
    valid_nxt = valid_r;
    out_nxt   = out_r;
    if (out_pop && valid_r) begin
      valid_nxt = 1'b0;
    end
    if (q_pop) begin
      valid_nxt        = 1'b1;
      out_nxt.kind     = q_data.kind;
      out_nxt.x_bits   = q_data.x_bits;
      out_nxt.y_bits   = q_data.y_bits;
      out_nxt.z_bits   = q_data.z_bits;
      out_nxt.red      = expand5(q_data.color565[15:11]);
      out_nxt.green    = expand6(q_data.color565[10:5]);
      out_nxt.blue     = expand5(q_data.color565[4:0]);
      out_nxt.all_done = q_data.all_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

### rtl/point_cloud_bin_parser.sv
// Byte-serial parser for point-cloud bin files. One byte beat is taken every
// clock cycle while in_full is low; the parser state machine handles each byte
// as it is taken, and any point, file-done or error result it produces goes
// into a four-entry queue and then an output register before it shows on
// out_data. in_full rises only when the queue is full because results are
// not being popped. After a format or read error all further bytes are taken
// and dropped until reset.
module point_cloud_bin_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  pcbp_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output pcbp_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);
  import pcbp_pkg::*;

  logic ev_push;
  evt_t ev_data;
  evt_t q_data;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign in_full = q_full;

  pcbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .ev_push   (ev_push),
    .ev_data   (ev_data)
  );

  pcbp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (ev_push),
    .wdata_i (ev_data),
    .pop_i   (q_pop),
    .rdata_o (q_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  pcbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

### verif/testbench.sv
module testbench;
  import pcbp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  class parse_tracker;
    phase_t           phase;
    logic [31:0]      varint_acc;
    logic [31:0]      groups_left;
    logic [31:0]      pair_words_left;
    logic [31:0]      points_left;
    logic [3:0]       byte_idx;
    logic [2:0][31:0] coords;
    logic [7:0]       color_hi;
    logic [15:0]      version;
    logic [15:0]      files_done;
    logic [15:0]      expected_files;
    bit               halted;
    out_item_t        awaited_beats[$];
    int               mismatches;

    function new();
      expected_files = 16'd1;
      files_done = 16'd0;
      halted = 1'b0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_VER;
      byte_idx = 4'd0;
      varint_acc = 32'd0;
      groups_left = 32'd0;
      pair_words_left = 32'd0;
      points_left = 32'd0;
      color_hi = 8'd0;
      version = 16'd0;
      coords = '0;
    endfunction

    function bit idle();
      return phase == PH_VER && byte_idx == 4'd0;
    endfunction

    function void close_groups();
      if (groups_left != 32'd0) begin
        phase = PH_GROUPLEN;
      end else begin
        phase = PH_NPOINTS;
      end
    endfunction

    function void count_finished(input logic [31:0] raw);
      logic [31:0] n;
      n = (raw[31] || raw == 32'd0) ? 32'd0 : raw;
      case (phase)
        PH_NGROUPS: begin
          groups_left = n;
          close_groups();
        end
        PH_GROUPLEN: begin
          groups_left = groups_left - 32'd1;
          pair_words_left = n << 1;
          if (pair_words_left != 32'd0) begin
            phase = PH_PAIRS;
          end else begin
            close_groups();
          end
        end
        PH_PAIRS: begin
          pair_words_left = pair_words_left - 32'd1;
          if (pair_words_left == 32'd0) begin
            close_groups();
          end
        end
        default: begin
          points_left = n;
          byte_idx = 4'd0;
          if (n != 32'd0) begin
            phase = PH_RECORD;
          end else begin
            phase = PH_DONE;
          end
        end
      endcase
    endfunction

    function void note_byte(input in_item_t item);
      out_item_t   beat;
      logic [31:0] grown;
      logic [15:0] word;
      logic [7:0]  b;
      int          r;
      int          g;
      int          bl;
      b = item.data_byte;
      beat = '0;
      if (halted) begin
        return;
      end
      if (item.stream_end) begin
        if (item.first_byte || (!idle() && phase != PH_DONE)) begin
          halted = 1'b1;
          beat.kind = KIND_READ_ERR;
          awaited_beats.push_back(beat);
        end else if (phase == PH_DONE) begin
          if (files_done != 16'hFFFF) begin
            files_done = files_done + 16'd1;
          end
          restart();
          beat.kind = KIND_DONE;
          beat.all_done = (files_done == expected_files);
          awaited_beats.push_back(beat);
        end
        return;
      end
      if (item.first_byte) begin
        restart();
      end
      case (phase)
        PH_VER: begin
          case (byte_idx[1:0])
            2'd0: version = {b, 8'h00};
            2'd1: version = {version[15:8], b};
            2'd2: color_hi = b;
            default: begin
              word = {color_hi, b};
              byte_idx = 4'd0;
              color_hi = 8'd0;
              if (version != 16'd1 || word != 16'd0) begin
                halted = 1'b1;
                beat.kind = KIND_FMT_ERR;
                awaited_beats.push_back(beat);
              end else begin
                varint_acc = 32'd0;
                phase = PH_NGROUPS;
              end
              return;
            end
          endcase
          byte_idx = {2'b00, byte_idx[1:0]} + 4'd1;
        end
        PH_NGROUPS, PH_GROUPLEN, PH_PAIRS, PH_NPOINTS: begin
          grown = {varint_acc[24:0], b[6:0]};
          if (!b[7]) begin
            varint_acc = grown;
          end else begin
            varint_acc = 32'd0;
            count_finished(grown);
          end
        end
        PH_RECORD: begin
          if (byte_idx < 4'd12) begin
            coords[byte_idx[3:2]] = {coords[byte_idx[3:2]][23:0], b};
            byte_idx = byte_idx + 4'd1;
          end else if (byte_idx == 4'd12) begin
            color_hi = b;
            byte_idx = 4'd13;
          end else begin
            word = {color_hi, b};
            r = int'(word[15:11]);
            g = int'(word[10:5]);
            bl = int'(word[4:0]);
            beat.kind = KIND_POINT;
            beat.x_bits = coords[0];
            beat.y_bits = coords[1];
            beat.z_bits = coords[2];
            beat.red = 8'(r * 255 / 31);
            beat.green = 8'(g * 255 / 63);
            beat.blue = 8'(bl * 255 / 31);
            awaited_beats.push_back(beat);
            coords = '0;
            color_hi = 8'd0;
            byte_idx = 4'd0;
            if (points_left != 32'd0) begin
              points_left = points_left - 32'd1;
            end
            if (points_left == 32'd0) begin
              phase = PH_DONE;
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_beat(input out_item_t got);
      out_item_t want;
      if (awaited_beats.size() == 0) begin
        report_mismatch($sformatf("result of kind %0d with none awaited", got.kind));
        return;
      end
      want = awaited_beats.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.x_bits !== want.x_bits)
        report_mismatch($sformatf("x_bits %h, want %h", got.x_bits, want.x_bits));
      if (got.y_bits !== want.y_bits)
        report_mismatch($sformatf("y_bits %h, want %h", got.y_bits, want.y_bits));
      if (got.z_bits !== want.z_bits)
        report_mismatch($sformatf("z_bits %h, want %h", got.z_bits, want.z_bits));
      if (got.red !== want.red)
        report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
      if (got.green !== want.green)
        report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
      if (got.all_done !== want.all_done)
        report_mismatch($sformatf("all_done %b, want %b", got.all_done, want.all_done));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  in_item_t    in_data = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  parse_tracker tracker;
  bit           calm = 1'b0;
  bit           hold_request = 1'b0;
  int           bytes_taken = 0;
  int           cycle_count = 0;
  logic [7:0]   file_bytes[$];
  logic [7:0]   sample_file [25] = '{
    8'h00, 8'h01, 8'h00, 8'h00, 8'h81, 8'h81, 8'h7F, 8'hFF, 8'h80, 8'h81,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h80, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h55
  };

  point_cloud_bin_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input bit f, input bit e);
    in_item_t item;
    item.data_byte = b;
    item.first_byte = f;
    item.stream_end = e;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_data <= item;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    tracker.note_byte(item);
    bytes_taken++;
  endtask

  task automatic write_expected_files(input logic [15:0] v);
    in_push <= 1'b0;
    while (tracker.awaited_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.expected_files = v;
  endtask

  function automatic void put_varint(input logic [63:0] wide, input int groups);
    for (int i = groups - 1; i >= 0; i--) begin
      file_bytes.push_back({i == 0, wide[7 * i +: 7]});
    end
  endfunction

  function automatic int groups_for(input logic [63:0] wide);
    int g;
    g = 1;
    while (g < 9 && (wide >> (7 * g)) != 64'd0) g++;
    return g;
  endfunction

  // Counts come plain, padded with leading zero groups, with junk above bit 31,
  // or, for zero iterations, as a negative value.
  function automatic void put_count(input int n);
    logic [63:0] wide;
    int          style;
    wide = 64'(n);
    style = $urandom_range(0, 7);
    if (n == 0 && style < 2) begin
      wide = {$urandom, $urandom};
      wide[31] = 1'b1;
      put_varint(wide, $urandom_range(5, 9));
    end else if (style == 2) begin
      wide[63:32] = $urandom;
      put_varint(wide, $urandom_range(5, 9));
    end else if (style == 3) begin
      put_varint(wide, groups_for(wide) + $urandom_range(1, 2));
    end else begin
      put_varint(wide, groups_for(wide));
    end
  endfunction

  function automatic logic [7:0] record_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_file(input int lo_pts, input int hi_pts, input bit may_cut);
    int n_groups;
    int n_pairs;
    int n_points;
    int cut;
    bit first;
    file_bytes.delete();
    if (tracker.idle() && $urandom_range(0, 9) == 0) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h01);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h00);
    n_groups = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
    put_count(n_groups);
    for (int g = 0; g < n_groups; g++) begin
      n_pairs = $urandom_range(0, 2);
      put_count(n_pairs);
      for (int p = 0; p < 2 * n_pairs; p++) begin
        put_varint({$urandom, $urandom}, $urandom_range(1, 9));
      end
    end
    n_points = $urandom_range(lo_pts, hi_pts);
    put_count(n_points);
    repeat (14 * n_points) file_bytes.push_back(record_byte());
    repeat ($urandom_range(0, 2)) file_bytes.push_back(8'($urandom_range(0, 255)));
    cut = file_bytes.size();
    if (may_cut && $urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, file_bytes.size() - 1);
    end
    first = !tracker.idle() || ($urandom_range(0, 1) == 1);
    for (int i = 0; i < cut; i++) begin
      send_beat(file_bytes[i], i == 0 && first, 1'b0);
    end
    if (cut == file_bytes.size()) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  task automatic run_random(input int amount);
    int mark;
    mark = bytes_taken;
    while (bytes_taken - mark < amount) send_file(0, 4, 1'b1);
  endtask

  task automatic send_min_file();
    send_beat(8'h00, !tracker.idle() || ($urandom_range(0, 1) == 1), 1'b0);
    send_beat(8'h01, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h80, 1'b0, 1'b0);
    send_beat(8'h80, 1'b0, 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Only one error can be seen per run, since it holds until reset.
  task automatic break_stream();
    logic [15:0] major;
    logic [15:0] minor;
    logic [7:0]  good_head [5];
    int          k;
    good_head = '{8'h00, 8'h01, 8'h00, 8'h00, 8'h80};
    case ($urandom_range(0, 2))
      0: begin
        major = ($urandom_range(0, 1) == 1) ? 16'd1 : 16'($urandom_range(0, 65535));
        minor = 16'($urandom_range(0, 65535));
        if (major == 16'd1 && minor == 16'd0) begin
          minor = 16'h8000;
        end
        send_beat(major[15:8], !tracker.idle() || ($urandom_range(0, 1) == 1), 1'b0);
        send_beat(major[7:0], 1'b0, 1'b0);
        send_beat(minor[15:8], 1'b0, 1'b0);
        send_beat(minor[7:0], 1'b0, 1'b0);
      end
      1: begin
        k = $urandom_range(1, 5);
        for (int i = 0; i < k; i++) begin
          send_beat(good_head[i], i == 0, 1'b0);
        end
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
      default: send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endcase
    repeat (12) begin
      send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1,
                $urandom_range(0, 1) == 1);
    end
  endtask

  initial begin
    wait (rst_n);
    forever begin
      if (hold_request) begin
        out_pop <= 1'b0;
        repeat (300) @(posedge clk);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      if (!out_empty) begin
        tracker.check_beat(out_data);
      end
    end
  end

  initial begin
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_beat(8'hA5, 1'b0, 1'b1);
    foreach (sample_file[i]) send_beat(sample_file[i], 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    write_expected_files(16'h0000);
    hold_request = 1'b1;
    send_file(10, 12, 1'b0);
    run_random(150);
    write_expected_files(tracker.files_done + 16'($urandom_range(1, 6)));
    run_random(150);
    write_expected_files(16'($urandom_range(0, 65535)));
    run_random(150);
    calm = 1'b1;
    write_expected_files(tracker.files_done + 16'd2);
    repeat (2) send_min_file();
    break_stream();
    in_push <= 1'b0;
    while (tracker.awaited_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
